// ----- src/ate_pkg.sv -----
// Shared constants, types and tables for the accelerometer tilt estimator.
// Used by the controller, the datapath and its arithmetic units.
package ate_pkg;

  // Algorithm settings
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int PRE_SHIFT       = 8;
  localparam int ACC_FRAC        = 20;
  localparam int TABLE_LEN       = 24;

  // Port field widths
  localparam int IN_W    = 16;
  localparam int ROLL_W  = 16;
  localparam int PITCH_W = 15;

  // CORDIC vector and angle accumulator widths
  localparam int VEC_W = 27;
  localparam int ACC_W = 30;

  // Magnitude unit widths: radicand is (y^2 + z^2) scaled by 2^(2*PRE_SHIFT)
  localparam int SQ_W   = 2 * IN_W;
  localparam int RAD_W  = SQ_W + 2 * PRE_SHIFT;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  // Step counter covers the root digits and every CORDIC step
  localparam int CNT_W = $clog2(ROOT_W);

  // Output angle scaling
  localparam int ANG_W  = 9 + ANGLE_FRAC_BITS;
  localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int SCL_W  = ACC_W - RND_SH;
  localparam logic signed [ANG_W-1:0] FULL_ANG = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] HALF_ANG = ANG_W'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] START_Z  = ACC_W'(180 << ACC_FRAC);

  // Smoothing: divide by five through a reciprocal multiply
  localparam int SUM_W   = ANG_W + 3;
  localparam int DIV_SH  = ANG_W + 4;
  localparam int MUL_W   = DIV_SH - 2;
  localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'((64'd1 << DIV_SH) / 5 + 1);

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQY,
    ST_SQZ,
    ST_ROOT,
    ST_LOADP,
    ST_PITCH,
    ST_FINP,
    ST_SMR,
    ST_SMP
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             sq_y;
    logic             sq_z;
    logic             root_step;
    logic             cordic_step;
    logic             load_pitch;
    logic             fin_pitch;
    logic             smooth_roll;
    logic             smooth_pitch;
    logic [CNT_W-1:0] step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } status_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [ACC_W-1:0] atan_tab(input logic [CNT_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      5'd0:    v = ACC_W'(47185920);
      5'd1:    v = ACC_W'(27855475);
      5'd2:    v = ACC_W'(14718068);
      5'd3:    v = ACC_W'(7471121);
      5'd4:    v = ACC_W'(3750058);
      5'd5:    v = ACC_W'(1876857);
      5'd6:    v = ACC_W'(938658);
      5'd7:    v = ACC_W'(469357);
      5'd8:    v = ACC_W'(234682);
      5'd9:    v = ACC_W'(117342);
      5'd10:   v = ACC_W'(58671);
      5'd11:   v = ACC_W'(29335);
      5'd12:   v = ACC_W'(14668);
      5'd13:   v = ACC_W'(7334);
      5'd14:   v = ACC_W'(3667);
      5'd15:   v = ACC_W'(1833);
      5'd16:   v = ACC_W'(917);
      5'd17:   v = ACC_W'(458);
      5'd18:   v = ACC_W'(229);
      5'd19:   v = ACC_W'(115);
      5'd20:   v = ACC_W'(57);
      5'd21:   v = ACC_W'(29);
      5'd22:   v = ACC_W'(14);
      5'd23:   v = ACC_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- src/accel_tilt_estimator.sv -----
// Accelerometer tilt estimator: roll and pitch by CORDIC, smoothed per sample.
// A request runs through the squares, the 24-step magnitude root (roll CORDIC runs
// alongside), the 16-step pitch CORDIC and smoothing before its result is valid.
// A new request is accepted only after the previous one has been smoothed into the output register.
// A finished result waits in the output register while the next request runs.
// Reset clears the controller, the output valid and both smoothed angles.
module accel_tilt_estimator import ate_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [IN_W-1:0]    accel_x_i,
  input  logic signed [IN_W-1:0]    accel_y_i,
  input  logic signed [IN_W-1:0]    accel_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ROLL_W-1:0]  roll_angle_o,
  output logic signed [PITCH_W-1:0] pitch_angle_o
);

  cmd_t    cmd;
  status_t status;

  ate_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ate_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o)
  );

endmodule

// ----- src/ate_cordic.sv -----
// CORDIC vectoring unit: one micro-rotation per step, angle in 2^-20 degree.
// Depends on ate_pkg for widths and the arctangent table.
module ate_cordic import ate_pkg::*; (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic                    step_i,
  input  logic [CNT_W-1:0]        idx_i,
  input  logic signed [VEC_W-1:0] x_i,
  input  logic signed [VEC_W-1:0] y_i,
  output logic signed [ACC_W-1:0] z_o,
  output logic                    zero_o
);

  logic signed [VEC_W-1:0] x_q, y_q;
  logic signed [ACC_W-1:0] z_q;
  logic                    zero_q;
  logic signed [VEC_W-1:0] xs, ys;
  logic signed [ACC_W-1:0] ang;

  // Shifted operands and table angle for the current step
  always_comb begin
    xs  = x_q >>> idx_i;
    ys  = y_q >>> idx_i;
    ang = atan_tab(idx_i);
  end

  // Vector load with half-plane fold, then micro-rotations toward y = 0
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= (y_i >= 0) ? START_Z : -START_Z;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (step_i) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
    end
  end

  assign z_o    = z_q;
  assign zero_o = zero_q;

endmodule

// ----- src/ate_isqrt.sv -----
// Bit-serial integer square root: one result bit per step, restoring form.
// Depends on ate_pkg for the radicand and root widths.
module ate_isqrt import ate_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic              step_i,
  input  logic [SQ_W-1:0]   sq_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_n, trial;

  // Bring down the next two radicand bits and form the trial subtrahend
  always_comb begin
    rem_n = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rad_q  <= {sq_i, {(2 * PRE_SHIFT){1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (step_i) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;

endmodule

// ----- src/ate_datapath.sv -----
// Datapath: sample registers, squares, magnitude root, shared CORDIC,
// angle scaling, smoothing and the output register. Uses ate_pkg,
// ate_cordic and ate_isqrt.
module ate_datapath import ate_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  output status_t                   status_o,
  input  logic signed [IN_W-1:0]    accel_x_i,
  input  logic signed [IN_W-1:0]    accel_y_i,
  input  logic signed [IN_W-1:0]    accel_z_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic signed [ROLL_W-1:0]  roll_angle_o,
  output logic signed [PITCH_W-1:0] pitch_angle_o
);

  logic signed [IN_W-1:0]    ax_q, ay_q, az_q;
  logic [SQ_W-1:0]           sq_q;
  logic signed [ANG_W-1:0]   roll_meas_q, pitch_meas_q;
  logic signed [ANG_W-1:0]   prev_roll_q, prev_pitch_q;
  logic                      out_valid_q;
  logic signed [ROLL_W-1:0]  roll_out_q;
  logic signed [PITCH_W-1:0] pitch_out_q;

  logic signed [IN_W-1:0]    mul_op;
  logic signed [SQ_W-1:0]    prod;
  logic [SQ_W-1:0]           sq_sum;
  logic signed [VEC_W-1:0]   cx, cy;
  logic signed [ACC_W-1:0]   cz;
  logic                      czero;
  logic [ROOT_W-1:0]         root;
  logic signed [ANG_W-1:0]   scaled;
  logic signed [ANG_W-1:0]   sm_last, sm_meas, sm_res;

  // Widen a sample and scale it into the CORDIC range
  function automatic logic signed [VEC_W-1:0] widen(input logic signed [IN_W-1:0] v);
    logic signed [VEC_W-1:0] e;
    e = {{(VEC_W - IN_W){v[IN_W-1]}}, v};
    return e <<< PRE_SHIFT;
  endfunction

  // Round the accumulator to output units and clamp to +-limit; a zero vector gives zero
  function automatic logic signed [ANG_W-1:0] to_angle(input logic signed [ACC_W-1:0] z,
                                                       input logic zero,
                                                       input logic signed [ANG_W-1:0] lim);
    logic signed [ACC_W-1:0] t;
    logic signed [SCL_W-1:0] r, l;
    logic signed [ANG_W-1:0] res;
    t = z + ACC_W'(64'd1 << (RND_SH - 1));
    r = t[ACC_W-1:RND_SH];
    l = {{(SCL_W - ANG_W){lim[ANG_W-1]}}, lim};
    if (zero)       res = '0;
    else if (r > l) res = lim;
    else if (r < -l) res = -lim;
    else            res = r[ANG_W-1:0];
    return res;
  endfunction

  // (3*last + 2*meas)/5 rounded to nearest, by reciprocal multiply
  function automatic logic signed [ANG_W-1:0] smooth(input logic signed [ANG_W-1:0] last,
                                                     input logic signed [ANG_W-1:0] meas);
    logic signed [SUM_W-1:0]   l, m, s;
    logic [SUM_W-1:0]          a;
    logic [SUM_W+MUL_W-1:0]    p;
    logic signed [ANG_W-1:0]   q;
    l = {{(SUM_W - ANG_W){last[ANG_W-1]}}, last};
    m = {{(SUM_W - ANG_W){meas[ANG_W-1]}}, meas};
    s = (l <<< 1) + l + (m <<< 1);
    a = (s < 0) ? SUM_W'(-s) + SUM_W'(2) : SUM_W'(s) + SUM_W'(2);
    p = {{MUL_W{1'b0}}, a} * {{SUM_W{1'b0}}, DIV_MUL};
    q = p[DIV_SH +: ANG_W];
    return (s < 0) ? -q : q;
  endfunction

  // One squarer shared by the y and z terms
  always_comb begin
    mul_op = cmd_i.sq_z ? az_q : ay_q;
    prod   = mul_op * mul_op;
    sq_sum = sq_q + SQ_W'(prod);
  end

  // CORDIC source: roll vector straight from the request, pitch from registers
  always_comb begin
    if (cmd_i.load) begin
      cx = widen(accel_z_i);
      cy = widen(accel_y_i);
    end else begin
      cx = {{(VEC_W - ROOT_W){1'b0}}, root};
      cy = -widen(ax_q);
    end
  end

  ate_cordic u_cordic (
    .clk_i  (clk_i),
    .load_i (cmd_i.load | cmd_i.load_pitch),
    .step_i (cmd_i.cordic_step),
    .idx_i  (cmd_i.step),
    .x_i    (cx),
    .y_i    (cy),
    .z_o    (cz),
    .zero_o (czero)
  );

  ate_isqrt u_isqrt (
    .clk_i  (clk_i),
    .load_i (cmd_i.sq_z),
    .step_i (cmd_i.root_step),
    .sq_i   (sq_sum),
    .root_o (root)
  );

  // Scaling limit follows the angle being finished; smoothing operand select
  always_comb begin
    scaled  = to_angle(cz, czero, cmd_i.load_pitch ? FULL_ANG : HALF_ANG);
    sm_last = cmd_i.smooth_pitch ? prev_pitch_q : prev_roll_q;
    sm_meas = cmd_i.smooth_pitch ? pitch_meas_q : roll_meas_q;
    sm_res  = smooth(sm_last, sm_meas);
  end

  // Sample, square, measured-angle and output angle registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
    end
    if (cmd_i.sq_y)       sq_q         <= SQ_W'(prod);
    if (cmd_i.load_pitch) roll_meas_q  <= scaled;
    if (cmd_i.fin_pitch)  pitch_meas_q <= scaled;
    if (cmd_i.smooth_pitch) begin
      roll_out_q  <= prev_roll_q[ROLL_W-1:0];
      pitch_out_q <= sm_res[PITCH_W-1:0];
    end
  end

  // Filter state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_roll_q  <= '0;
      prev_pitch_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.smooth_roll)  prev_roll_q  <= sm_res;
      if (cmd_i.smooth_pitch) prev_pitch_q <= sm_res;
      if (cmd_i.smooth_pitch) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_busy = out_valid_q & out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign roll_angle_o      = roll_out_q;
  assign pitch_angle_o     = pitch_out_q;

endmodule

// ----- src/ate_ctrl.sv -----
// Controller: sequences squares, root, both CORDIC passes and smoothing.
// Depends on ate_pkg for the state enum and command/status structs.
module ate_ctrl import ate_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [CNT_W-1:0] ROOT_LAST   = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] CORDIC_CNT  = CNT_W'(CORDIC_STEPS);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.step = cnt_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQY;
        end
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        state_d    = ST_SQZ;
      end
      ST_SQZ: begin
        cmd_o.sq_z = 1'b1;
        cnt_d      = '0;
        state_d    = ST_ROOT;
      end
      // Root digits and roll rotations share the counter
      ST_ROOT: begin
        cmd_o.root_step   = 1'b1;
        cmd_o.cordic_step = (cnt_q < CORDIC_CNT);
        if (cnt_q == ROOT_LAST) begin
          cnt_d   = '0;
          state_d = ST_LOADP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LOADP: begin
        cmd_o.load_pitch = 1'b1;
        cnt_d            = '0;
        state_d          = ST_PITCH;
      end
      ST_PITCH: begin
        cmd_o.cordic_step = 1'b1;
        if (cnt_q == CORDIC_LAST) begin
          cnt_d   = '0;
          state_d = ST_FINP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINP: begin
        cmd_o.fin_pitch = 1'b1;
        state_d         = ST_SMR;
      end
      ST_SMR: begin
        cmd_o.smooth_roll = 1'b1;
        state_d           = ST_SMP;
      end
      // Hold until the output register is free
      ST_SMP: begin
        if (!status_i.out_busy) begin
          cmd_o.smooth_pitch = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- verif/accel_tilt_checker.sv -----
// Checker for the accelerometer tilt estimator: watches both channels, predicts roll and
// pitch per accepted request and compares every accepted result in order.
// Depends on ate_pkg for field widths and fixed-point settings.
module accel_tilt_checker import ate_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic signed [IN_W-1:0]    accel_x_i,
  input  logic signed [IN_W-1:0]    accel_y_i,
  input  logic signed [IN_W-1:0]    accel_z_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [ROLL_W-1:0]  roll_angle_i,
  input  logic signed [PITCH_W-1:0] pitch_angle_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        checked_o
);

  typedef struct {
    int                        sample;
    logic signed [ROLL_W-1:0]  roll;
    logic signed [PITCH_W-1:0] pitch;
  } tilt_t;

  tilt_t  predicted_tilt[$];
  longint smoothed_roll  = 0;
  longint smoothed_pitch = 0;
  int     n_fail    = 0;
  int     n_checked = 0;
  int     n_samples = 0;

  // atan(2^-i) in 2^-20 degree units
  function automatic longint atan_step_q20(input int idx);
    case (idx)
      0:       return 47185920;
      1:       return 27855475;
      2:       return 14718068;
      3:       return 7471121;
      4:       return 3750058;
      5:       return 1876857;
      6:       return 938658;
      7:       return 469357;
      8:       return 234682;
      9:       return 117342;
      10:      return 58671;
      11:      return 29335;
      12:      return 14668;
      13:      return 7334;
      14:      return 3667;
      15:      return 1833;
      16:      return 917;
      17:      return 458;
      18:      return 229;
      19:      return 115;
      20:      return 57;
      21:      return 29;
      22:      return 14;
      23:      return 7;
      default: return 0;
    endcase
  endfunction

  // floor(sqrt(v)), digit by digit
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned rem  = v;
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // atan2(num, den) by CORDIC vectoring, 2^-20 degree units
  function automatic longint cordic_atan2(input longint num, input longint den);
    longint xv  = den;
    longint yv  = num;
    longint acc = 0;
    longint xs, ys;
    if (xv == 0 && yv == 0) return 0;
    // left half plane: flip by 180 degrees, zero numerator goes to +180
    if (xv < 0) begin
      acc = (yv >= 0) ? (longint'(180) << ACC_FRAC) : -(longint'(180) << ACC_FRAC);
      xv  = -xv;
      yv  = -yv;
    end
    for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv  = xv + ys;
        yv  = yv - xs;
        acc = acc + atan_step_q20(i);
      end else begin
        xv  = xv - ys;
        yv  = yv + xs;
        acc = acc - atan_step_q20(i);
      end
    end
    return acc;
  endfunction

  // round half up to the output LSB, then clamp to +-limit
  function automatic longint angle_to_output(input longint acc, input longint limit);
    int     sh = ACC_FRAC - ANGLE_FRAC_BITS;
    longint r;
    r = (acc + (longint'(1) << (sh - 1))) >>> sh;
    if (r > limit) r = limit;
    if (r < -limit) r = -limit;
    return r;
  endfunction

  // (3*last + 2*meas) / 5, rounded to nearest
  function automatic longint blend_3_2(input longint last, input longint meas);
    longint s = 3 * last + 2 * meas;
    if (s >= 0) return (s + 2) / 5;
    return -((-s + 2) / 5);
  endfunction

  function automatic void update_tilt(input logic signed [IN_W-1:0] x, y, z,
                                      inout longint roll_st, inout longint pitch_st);
    longint ax, ay, az, mag, roll_m, pitch_m;
    ax = x;
    ay = y;
    az = z;
    mag = longint'(isqrt(longint'(ay * ay + az * az) << (2 * PRE_SHIFT)));
    roll_m  = angle_to_output(cordic_atan2(ay <<< PRE_SHIFT, az <<< PRE_SHIFT),
                              longint'(180) << ANGLE_FRAC_BITS);
    pitch_m = angle_to_output(cordic_atan2(-(ax <<< PRE_SHIFT), mag),
                              longint'(90) << ANGLE_FRAC_BITS);
    roll_st  = blend_3_2(roll_st, roll_m);
    pitch_st = blend_3_2(pitch_st, pitch_m);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tilt_t want;
    if (!rst_ni) begin
      smoothed_roll  = 0;
      smoothed_pitch = 0;
      predicted_tilt.delete();
      pending_o <= 0;
    end else begin
      // results taken from the block
      if (out_valid_i && !out_stall_i) begin
        if (predicted_tilt.size() == 0) begin
          n_fail++;
          $display("%0t: result with nothing expected: roll %0d pitch %0d",
                   $time, roll_angle_i, pitch_angle_i);
        end else begin
          want = predicted_tilt.pop_front();
          n_checked++;
          if (roll_angle_i !== want.roll) begin
            n_fail++;
            $display("%0t: sample %0d roll: expected %0d, got %0d",
                     $time, want.sample, want.roll, roll_angle_i);
          end
          if (pitch_angle_i !== want.pitch) begin
            n_fail++;
            $display("%0t: sample %0d pitch: expected %0d, got %0d",
                     $time, want.sample, want.pitch, pitch_angle_i);
          end
        end
      end
      // requests accepted by the block
      if (in_valid_i && !in_stall_i) begin
        update_tilt(accel_x_i, accel_y_i, accel_z_i, smoothed_roll, smoothed_pitch);
        want.sample = n_samples;
        want.roll   = ROLL_W'(smoothed_roll);
        want.pitch  = PITCH_W'(smoothed_pitch);
        predicted_tilt.push_back(want);
        n_samples++;
      end
      fail_count_o <= n_fail;
      pending_o    <= predicted_tilt.size();
      checked_o    <= n_checked;
    end
  end

endmodule

// ----- verif/accel_tilt_estimator_tb.sv -----
// Testbench top for the accelerometer tilt estimator: clock, reset, sample requests,
// result stalls and the verdict. Depends on ate_pkg, the block and accel_tilt_checker.
module accel_tilt_estimator_tb;
  import ate_pkg::*;

  localparam int RANDOM_SAMPLES = 1530;
  localparam int HOLD_START     = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 60;

  localparam logic signed [IN_W-1:0] ZERO  = '0;
  localparam logic signed [IN_W-1:0] POS1  = 16'sd1;
  localparam logic signed [IN_W-1:0] NEG1  = -16'sd1;
  localparam logic signed [IN_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [IN_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [IN_W-1:0] ONE_G = 16'sd16384;
  localparam logic signed [IN_W-1:0] NEG_G = -16'sd16384;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [IN_W-1:0]    accel_x   = '0;
  logic signed [IN_W-1:0]    accel_y   = '0;
  logic signed [IN_W-1:0]    accel_z   = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [ROLL_W-1:0]  roll_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  int                        fail_count;
  int                        pending;
  int                        checked;

  int                        sent       = 0;
  int                        directed   = 0;
  int                        burst_left = 0;
  logic signed [IN_W-1:0]    last_x = '0, last_y = '0, last_z = '0;

  always #5 clk = ~clk;

  accel_tilt_estimator uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .roll_angle_o  (roll_angle),
    .pitch_angle_o (pitch_angle)
  );

  accel_tilt_checker tilt_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .accel_x_i     (accel_x),
    .accel_y_i     (accel_y),
    .accel_z_i     (accel_z),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .roll_angle_i  (roll_angle),
    .pitch_angle_i (pitch_angle),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // zero, +-1, full scale or anything
  function automatic logic signed [IN_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return ZERO;
      1:       return POS1;
      2:       return NEG1;
      3:       return S_MAX;
      4:       return S_MIN;
      default: return IN_W'($urandom);
    endcase
  endfunction

  // one request; bursts of back-to-back requests separated by random gaps
  task automatic offer_sample(input logic signed [IN_W-1:0] x, y, z);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    accel_x  <= x;
    accel_y  <= y;
    accel_z  <= z;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    last_x = x;
    last_y = y;
    last_z = z;
  endtask

  // result side: segments of different stall density, one long hold-off
  initial begin : result_taker
    int cycle     = 0;
    int seg_left  = 0;
    int run_left  = 0;
    int stall_pct = 0;
    bit run_stall = 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle == HOLD_START) begin
        // results back up into the block until it stalls requests
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(100, 600);
          case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 30;
            default: stall_pct = 70;
          endcase
        end
        seg_left--;
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 99) < stall_pct);
          run_left  = $urandom_range(1, 24);
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  initial begin : stimulus
    logic signed [IN_W-1:0] x, y, z;
    int kind;
    int waited;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, axis-aligned, roll near +-180, pitch +-90, full scale
    offer_sample(ZERO, ZERO, ZERO);
    offer_sample(ZERO, ZERO, ONE_G);
    offer_sample(ZERO, ZERO, NEG_G);
    offer_sample(ZERO, ONE_G, ZERO);
    offer_sample(ZERO, NEG_G, ZERO);
    offer_sample(ZERO, NEG1, S_MIN);
    offer_sample(ZERO, POS1, S_MIN);
    offer_sample(ZERO, ZERO, NEG1);
    offer_sample(S_MIN, ZERO, ZERO);
    offer_sample(S_MAX, ZERO, ZERO);
    offer_sample(S_MAX, S_MAX, S_MAX);
    offer_sample(S_MIN, S_MIN, S_MIN);
    offer_sample(S_MIN, S_MAX, S_MIN);
    offer_sample(S_MAX, S_MIN, S_MAX);
    offer_sample(ONE_G, NEG_G, ONE_G);
    offer_sample(POS1, POS1, POS1);
    offer_sample(NEG1, NEG1, NEG1);
    offer_sample(ZERO, S_MIN, S_MIN);
    offer_sample(ZERO, S_MIN, ZERO);
    offer_sample(S_MIN, S_MAX, ZERO);
    // upside down and held: smoothing walks roll toward the 180 degree clamp
    repeat (4) offer_sample(ZERO, ZERO, S_MIN);
    directed = sent;

    // random samples
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        x = IN_W'($urandom);
        y = IN_W'($urandom);
        z = IN_W'($urandom);
      end else if (kind < 65) begin
        // around one g of tilt
        x = IN_W'(int'($urandom_range(0, 40000)) - 20000);
        y = IN_W'(int'($urandom_range(0, 40000)) - 20000);
        z = IN_W'(int'($urandom_range(0, 40000)) - 20000);
      end else if (kind < 75) begin
        x = IN_W'(int'($urandom_range(0, 8)) - 4);
        y = IN_W'(int'($urandom_range(0, 8)) - 4);
        z = IN_W'(int'($urandom_range(0, 8)) - 4);
      end else if (kind < 85) begin
        // steady sample lets the smoothing settle
        x = last_x;
        y = last_y;
        z = last_z;
      end else if (kind < 95) begin
        x = corner_value();
        y = corner_value();
        z = corner_value();
      end else begin
        // roll across the +-180 seam
        x = IN_W'($urandom);
        y = IN_W'(int'($urandom_range(0, 4)) - 2);
        z = IN_W'(-int'($urandom_range(1, 32768)));
      end
      offer_sample(x, y, z);
    end
    in_valid <= 1'b0;

    // drain, then give the block time for anything stray
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending != 0)
      $display("%0t: %0d expected results never arrived", $time, pending);
    $display("summary: %0d samples sent (%0d directed corners), %0d results checked",
             sent, directed, checked);
    $display("summary: random stalls on both sides plus a %0d-cycle result hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("accel_tilt_estimator_tb: PASS");
    end else begin
      $display("accel_tilt_estimator_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $display("%0t: run timed out", $time);
    $display("accel_tilt_estimator_tb: FAIL");
    $finish;
  end

endmodule
